[design/ralu_pkg.sv]
// Shared types and constants for the register ALU with NZCV flags.
// Holds the operation codes, the decoded command and the result item formats.
// No dependencies.
package ralu_pkg;

  localparam int REG_IDX_W    = 3;
  localparam int DATA_W       = 32;
  localparam int KIND_W       = 4;
  localparam int SHAMT_W      = 5;
  localparam int NUM_REGS_DEF = 8;
  localparam int CMDQ_DEPTH   = 2;
  localparam int RESQ_DEPTH   = 2;

  // Bit positions of the condition flags.
  localparam int FLG_N = 3;
  localparam int FLG_Z = 2;
  localparam int FLG_C = 1;
  localparam int FLG_V = 0;

  typedef enum logic [KIND_W-1:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_AND = 4'd2,
    OP_NOT = 4'd3,
    OP_ORR = 4'd4,
    OP_XOR = 4'd5,
    OP_LSR = 4'd6,
    OP_LSL = 4'd7,
    OP_MOV = 4'd8
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic                 op_ok;
    logic                 setf;
    logic [REG_IDX_W-1:0] dest;
    logic                 dest_ok;
    logic [REG_IDX_W-1:0] src1;
    logic                 src1_ok;
    logic [REG_IDX_W-1:0] src2;
    logic                 src2_ok;
    logic [SHAMT_W-1:0]   sh;
    logic [DATA_W-1:0]    imm;
  } cmd_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0] wreg;
    logic [DATA_W-1:0]    wval;
    logic                 n;
    logic                 z;
    logic                 c;
    logic                 v;
  } res_t;

endpackage

[design/ralu_fifo.sv]
// Small first-in first-out queue used between the front and back ends and on the result side.
// Depends on nothing but its parameters.
module ralu_fifo #(
  parameter int DW    = 8,
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  logic [DW-1:0] wdata,
  input  logic          pop,
  output logic          empty,
  output logic [DW-1:0] rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DW-1:0]    mem [DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= wdata;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue occupancy beyond its depth");

  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("queue occupancy did not rise on a lone push");

  a_cnt_down: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> (cnt_r == $past(cnt_r) - CNT_W'(1)))
    else $error("queue occupancy did not fall on a lone pop");
`endif

endmodule

[design/ralu_front.sv]
// Front end of the register ALU: takes input items and decodes them into commands.
// Depends on ralu_pkg for the operation codes and the command format.
module ralu_front #(
  parameter int NUM_REGS = ralu_pkg::NUM_REGS_DEF
) (
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [ralu_pkg::KIND_W-1:0]    in_kind,
  input  logic                           in_set_flags,
  input  logic [ralu_pkg::REG_IDX_W-1:0] in_dest_reg,
  input  logic [ralu_pkg::REG_IDX_W-1:0] in_src1_reg,
  input  logic [ralu_pkg::REG_IDX_W-1:0] in_src2_reg,
  input  logic [ralu_pkg::SHAMT_W-1:0]   in_shift_amount,
  input  logic [ralu_pkg::DATA_W-1:0]    in_immediate,
  output logic                           cq_push,
  input  logic                           cq_full,
  output ralu_pkg::cmd_t                 cq_cmd
);

  import ralu_pkg::*;

  logic kind_ok;

  // Codes above the move are unused: such an item writes nothing and keeps the flags.
  assign kind_ok = (in_kind <= OP_MOV);
  assign in_full = cq_full;
  assign cq_push = in_push && !cq_full;

  always_comb begin
    cq_cmd         = '0;
    cq_cmd.op      = kind_ok ? op_t'(in_kind) : OP_ADD;
    cq_cmd.op_ok   = kind_ok;
    cq_cmd.setf    = in_set_flags && kind_ok && (in_kind != OP_MOV);
    cq_cmd.dest    = in_dest_reg;
    cq_cmd.dest_ok = (int'(in_dest_reg) < NUM_REGS);
    cq_cmd.src1    = in_src1_reg;
    cq_cmd.src1_ok = (int'(in_src1_reg) < NUM_REGS);
    cq_cmd.src2    = in_src2_reg;
    cq_cmd.src2_ok = (int'(in_src2_reg) < NUM_REGS);
    cq_cmd.sh      = in_shift_amount;
    cq_cmd.imm     = in_immediate;
  end

endmodule

[design/ralu_back.sv]
// Back end of the register ALU: register file, operand read, execute and flag update.
// Depends on ralu_pkg for the operation codes, flag positions and item formats.
module ralu_back #(
  parameter int NUM_REGS = ralu_pkg::NUM_REGS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  ralu_pkg::cmd_t cq_cmd,
  input  logic           cq_empty,
  output logic           cq_pop,
  output ralu_pkg::res_t rq_res,
  output logic           rq_push,
  input  logic           rq_full
);

  import ralu_pkg::*;

  localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  logic [DATA_W-1:0]   rf_mem [NUM_REGS];
  logic [NUM_REGS-1:0] rf_vld_r;
  cmd_t                ex_cmd_r;
  logic                ex_vld_r;
  logic [DATA_W-1:0]   opa_r;
  logic [DATA_W-1:0]   opb_r;
  logic [3:0]          nzcv_r, nzcv_nxt;

  logic [IDX_W-1:0]    rd1_idx, rd2_idx, wr_idx;
  logic                commit, ex_adv, issue, wr_en;
  logic                byp1, byp2;
  logic [DATA_W-1:0]   res_val;
  logic [DATA_W-1:0]   bsel;
  logic [DATA_W:0]     sum;
  logic [DATA_W:0]     shr;
  logic [DATA_W:0]     shl;
  logic                is_sub;

  if (IDX_W <= REG_IDX_W) begin : g_idx_narrow
    assign rd1_idx = cq_cmd.src1[IDX_W-1:0];
    assign rd2_idx = cq_cmd.src2[IDX_W-1:0];
    assign wr_idx  = ex_cmd_r.dest[IDX_W-1:0];
  end else begin : g_idx_wide
    assign rd1_idx = {{(IDX_W-REG_IDX_W){1'b0}}, cq_cmd.src1};
    assign rd2_idx = {{(IDX_W-REG_IDX_W){1'b0}}, cq_cmd.src2};
    assign wr_idx  = {{(IDX_W-REG_IDX_W){1'b0}}, ex_cmd_r.dest};
  end

  // The execute stage retires when the result queue has room; a new command
  // enters whenever the stage is empty or retiring in the same cycle.
  assign commit = ex_vld_r && !rq_full;
  assign ex_adv = !ex_vld_r || commit;
  assign issue  = !cq_empty && ex_adv;
  assign cq_pop = issue;
  assign wr_en  = commit && ex_cmd_r.op_ok && ex_cmd_r.dest_ok;

  // A source read in the cycle its register is being written takes the new value.
  assign byp1 = wr_en && cq_cmd.src1_ok && (wr_idx == rd1_idx);
  assign byp2 = wr_en && cq_cmd.src2_ok && (wr_idx == rd2_idx);

  always_comb begin
    is_sub = (ex_cmd_r.op == OP_SUB);
    bsel   = is_sub ? ~opb_r : opb_r;
    sum    = {1'b0, opa_r} + {1'b0, bsel} + {{DATA_W{1'b0}}, is_sub};
    shr    = {opa_r, 1'b0} >> ex_cmd_r.sh;
    shl    = {1'b0, opa_r} << ex_cmd_r.sh;
    case (ex_cmd_r.op)
      OP_ADD:  res_val = sum[DATA_W-1:0];
      OP_SUB:  res_val = sum[DATA_W-1:0];
      OP_AND:  res_val = opa_r & opb_r;
      OP_NOT:  res_val = ~opa_r;
      OP_ORR:  res_val = opa_r | opb_r;
      OP_XOR:  res_val = opa_r ^ opb_r;
      OP_LSR:  res_val = shr[DATA_W:1];
      OP_LSL:  res_val = shl[DATA_W-1:0];
      OP_MOV:  res_val = ex_cmd_r.imm;
      default: res_val = '0;
    endcase
    if (!ex_cmd_r.op_ok) begin
      res_val = '0;
    end
  end

  always_comb begin
    nzcv_nxt = nzcv_r;
    if (ex_cmd_r.setf) begin
      nzcv_nxt[FLG_N] = res_val[DATA_W-1];
      nzcv_nxt[FLG_Z] = (res_val == '0);
      if (ex_cmd_r.op inside {OP_ADD, OP_SUB}) begin
        nzcv_nxt[FLG_C] = sum[DATA_W];
        nzcv_nxt[FLG_V] = (opa_r[DATA_W-1] == bsel[DATA_W-1]) &&
                          (res_val[DATA_W-1] != opa_r[DATA_W-1]);
      end else if ((ex_cmd_r.op inside {OP_LSR, OP_LSL}) && (ex_cmd_r.sh != '0)) begin
        nzcv_nxt[FLG_C] = (ex_cmd_r.op == OP_LSR) ? shr[0] : shl[DATA_W];
      end
    end
  end

  always_comb begin
    rq_push     = commit;
    rq_res.wreg = ex_cmd_r.dest;
    rq_res.wval = res_val;
    rq_res.n    = nzcv_nxt[FLG_N];
    rq_res.z    = nzcv_nxt[FLG_Z];
    rq_res.c    = nzcv_nxt[FLG_C];
    rq_res.v    = nzcv_nxt[FLG_V];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_vld_r <= 1'b0;
      rf_vld_r <= '0;
      nzcv_r   <= '0;
    end else begin
      if (ex_adv) begin
        ex_vld_r <= issue;
      end
      if (wr_en) begin
        rf_vld_r[wr_idx] <= 1'b1;
      end
      if (commit) begin
        nzcv_r <= nzcv_nxt;
      end
    end
  end

  // Register file write and registered operand read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rf_mem[wr_idx] <= res_val;
    end
    if (issue) begin
      ex_cmd_r <= cq_cmd;
      if (!cq_cmd.src1_ok) begin
        opa_r <= '0;
      end else if (byp1) begin
        opa_r <= res_val;
      end else begin
        opa_r <= rf_vld_r[rd1_idx] ? rf_mem[rd1_idx] : '0;
      end
      if (!cq_cmd.src2_ok) begin
        opb_r <= '0;
      end else if (byp2) begin
        opb_r <= res_val;
      end else begin
        opb_r <= rf_vld_r[rd2_idx] ? rf_mem[rd2_idx] : '0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !commit |=> $stable(nzcv_r))
    else $error("flags changed without a retiring item");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ex_vld_r && !commit) |=> (ex_vld_r && $stable(ex_cmd_r) && $stable(opa_r)))
    else $error("stalled execute stage lost its command");

  a_logic_keeps_cv: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && (ex_cmd_r.op == OP_AND || ex_cmd_r.op == OP_NOT ||
                ex_cmd_r.op == OP_ORR || ex_cmd_r.op == OP_XOR ||
                ex_cmd_r.op == OP_MOV))
    |=> ($stable(nzcv_r[FLG_C]) && $stable(nzcv_r[FLG_V])))
    else $error("logic or move altered carry or overflow");

  a_bad_op_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && !ex_cmd_r.op_ok) |-> (!wr_en && res_val == '0))
    else $error("unused operation code wrote a register");
`endif

endmodule

[design/register_alu_with_nzcv_flags.sv]
// Top level of the register ALU with NZCV condition flags.
// Depends on ralu_pkg, ralu_fifo, ralu_front and ralu_back.
//
//   Channel  | Direction | Handshake        | Payload
//   ---------+-----------+------------------+-----------------------------------------
//   in_      | input     | in_push, in_full | kind, set_flags, dest/src regs, shift, imm
//   out_     | output    | out_pop, out_empty | written_reg, written_value, N Z C V flags
//
// The block sustains one item per clock cycle while the result queue has room, set by
// the single execute stage. Operands are read as a command enters that stage, which
// then computes and writes the register file and flags. An accepted item is written
// into the command queue, moves into the execute stage and then into the result queue.
// Reset (rst_n low at a clock edge) empties both queues, zeroes the flags and marks
// every register as zero through per-register valid bits; no clearing pass is needed.
// A stall on the output side fills the result queue, then holds the execute stage,
// and finally fills the command queue, at which point in_full rises.
module register_alu_with_nzcv_flags #(
  parameter int NUM_REGS = ralu_pkg::NUM_REGS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [ralu_pkg::KIND_W-1:0]    in_kind,
  input  logic                           in_set_flags,
  input  logic [ralu_pkg::REG_IDX_W-1:0] in_dest_reg,
  input  logic [ralu_pkg::REG_IDX_W-1:0] in_src1_reg,
  input  logic [ralu_pkg::REG_IDX_W-1:0] in_src2_reg,
  input  logic [ralu_pkg::SHAMT_W-1:0]   in_shift_amount,
  input  logic [ralu_pkg::DATA_W-1:0]    in_immediate,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [ralu_pkg::REG_IDX_W-1:0] out_written_reg,
  output logic [ralu_pkg::DATA_W-1:0]    out_written_value,
  output logic                           out_flag_n,
  output logic                           out_flag_z,
  output logic                           out_flag_c,
  output logic                           out_flag_v
);

  import ralu_pkg::*;

  // Front end to command queue.
  logic cq_push;
  logic cq_full;
  cmd_t cq_wcmd;

  // Command queue to back end.
  logic cq_empty;
  logic cq_pop;
  cmd_t cq_rcmd;

  // Back end to result queue.
  logic rq_push;
  logic rq_full;
  res_t rq_wres;
  res_t rq_rres;

  // The front end decodes each item as it is accepted and places it in the queue.
  ralu_front #(
    .NUM_REGS (NUM_REGS)
  ) u_front (
    .in_push         (in_push),
    .in_full         (in_full),
    .in_kind         (in_kind),
    .in_set_flags    (in_set_flags),
    .in_dest_reg     (in_dest_reg),
    .in_src1_reg     (in_src1_reg),
    .in_src2_reg     (in_src2_reg),
    .in_shift_amount (in_shift_amount),
    .in_immediate    (in_immediate),
    .cq_push         (cq_push),
    .cq_full         (cq_full),
    .cq_cmd          (cq_wcmd)
  );

  // The command queue lets the front keep accepting while the back end stalls.
  ralu_fifo #(
    .DW    ($bits(cmd_t)),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cq_push),
    .full  (cq_full),
    .wdata (cq_wcmd),
    .pop   (cq_pop),
    .empty (cq_empty),
    .rdata (cq_rcmd)
  );

  // Back end: holds the architectural state, executes one command per cycle unless stalled.
  ralu_back #(
    .NUM_REGS (NUM_REGS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cq_cmd   (cq_rcmd),
    .cq_empty (cq_empty),
    .cq_pop   (cq_pop),
    .rq_res   (rq_wres),
    .rq_push  (rq_push),
    .rq_full  (rq_full)
  );

  // The result queue separates the execute stage from the consumer.
  ralu_fifo #(
    .DW    ($bits(res_t)),
    .DEPTH (RESQ_DEPTH)
  ) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rq_push),
    .full  (rq_full),
    .wdata (rq_wres),
    .pop   (out_pop),
    .empty (out_empty),
    .rdata (rq_rres)
  );

  assign out_written_reg   = rq_rres.wreg;
  assign out_written_value = rq_rres.wval;
  assign out_flag_n        = rq_rres.n;
  assign out_flag_z        = rq_rres.z;
  assign out_flag_c        = rq_rres.c;
  assign out_flag_v        = rq_rres.v;

endmodule
